// ===== rtl/kcd_pkg.sv =====
// Shared types and constants of the key combination detector
`timescale 1ns / 1ps

package kcd_pkg;

  // field widths
  localparam int SCAN_W  = 8;
  localparam int KIND_W  = 2;
  localparam int TIMER_W = 16;
  localparam int COUNT_W = 3;
  localparam int TABLE_W = 64;
  localparam int IDX_W   = 2;
  localparam int CFG_IDX_W = 3;

  // input action codes
  localparam logic ACTION_KEY_DOWN = 1'b0;
  localparam logic ACTION_TICK     = 1'b1;

  // policy kinds
  localparam logic [KIND_W-1:0] KIND_ACTIVATE_KEYGUARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEVICELOCK_QUERY  = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYGUARD_ALLOWED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_TABLE       = 3'd4;

  // register reset values
  localparam logic [KIND_W-1:0]  POLICY_KIND_RESET   = KIND_ACTIVATE_KEYGUARD;
  localparam logic [TIMER_W-1:0] TIMEOUT_TICKS_RESET = 16'd100;

  // saturation point of the window counter
  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

endpackage

// ===== rtl/kcd_item_if.sv =====
// Input item channel: key-down event or timer tick
`timescale 1ns / 1ps

interface kcd_item_if
  import kcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [SCAN_W-1:0] scan_code;

  modport source (output valid, output action, output scan_code, input ready);
  modport sink   (input valid, input action, input scan_code, output ready);
endinterface

// ===== rtl/kcd_result_if.sv =====
// Result item channel: match flag, pending flag and shown primary code
`timescale 1ns / 1ps

interface kcd_result_if
  import kcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              match;
  logic              primary_pending;
  logic [SCAN_W-1:0] last_primary_code;

  modport source (output valid, output match, output primary_pending,
                  output last_primary_code, input ready);
  modport sink   (input valid, input match, input primary_pending,
                  input last_primary_code, output ready);
endinterface

// ===== rtl/kcd_cfg_if.sv =====
// Configuration write channel: register index and write data
`timescale 1ns / 1ps

interface kcd_cfg_if
  import kcd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TABLE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/key_combination_detector.sv =====
// Two-key lock combination detector, top level
`timescale 1ns / 1ps

// Watches key-down scan codes and timer ticks for a configured two-key
// combination. Each accepted item gives exactly one result: the match flag,
// the pending flag after the item, and the primary code of the last armed
// pair. An item is registered on entry and evaluated against all pairs in
// parallel from that input register, so a new item may be transferred every
// cycle while results are taken; the result is registered in the result
// register and held until taken, and that register lets one further item
// enter while a result waits to be taken. Configuration writes are always
// taken and apply from the next item; running state is not cleared by them.
module key_combination_detector
  import kcd_pkg::*;
#(
  parameter int NUM_PAIRS = 4,
  parameter int CODE_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  kcd_item_if.sink          item,
  kcd_result_if.source      result,
  kcd_cfg_if.sink           cfg
);

  localparam int PAIR_W = 2 * CODE_BITS;
  localparam int EXT_W  = NUM_PAIRS * PAIR_W + TABLE_W;

  // configuration registers
  logic [KIND_W-1:0]  policy_kind;
  logic               keyguard_allowed;
  logic [TIMER_W-1:0] timeout_ticks;
  logic [COUNT_W-1:0] pair_count;
  logic [TABLE_W-1:0] pair_table;

  // running state
  logic                 pending, pending_next;
  logic                 last_valid, last_valid_next;
  logic [IDX_W-1:0]     last_index, last_index_next;
  logic [NUM_PAIRS-1:0] candidate_mask, candidate_mask_next;
  logic                 timer_armed, timer_armed_next;
  logic [TIMER_W-1:0]   timer_count, timer_count_next;

  // input stage
  logic              s1_valid;
  logic              s1_action;
  logic [SCAN_W-1:0] s1_code;

  // result stage
  logic              res_valid;
  logic              res_match;
  logic              res_pending;
  logic [SCAN_W-1:0] res_code;

  logic advance;
  logic process;

  // datapath signals
  logic [EXT_W-1:0]     pair_table_ext;
  logic [PAIR_W-1:0]    pair_word [NUM_PAIRS];
  logic [CODE_BITS-1:0] prim [NUM_PAIRS];
  logic [CODE_BITS-1:0] sec  [NUM_PAIRS];
  logic [CODE_BITS-1:0] code_ext;
  logic [COUNT_W-1:0]   eff_count;
  logic [NUM_PAIRS-1:0] prim_hit;
  logic [NUM_PAIRS-1:0] sec_hit;
  logic [IDX_W-1:0]     first_idx;
  logic                 enabled;
  logic                 match_next;
  logic [TIMER_W-1:0]   timer_inc;
  logic [SCAN_W-1:0]    sel_code;
  logic [SCAN_W-1:0]    shown_next;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_kind      <= POLICY_KIND_RESET;
      keyguard_allowed <= 1'b1;
      timeout_ticks    <= TIMEOUT_TICKS_RESET;
      pair_count       <= '0;
      pair_table       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_POLICY_KIND:      policy_kind      <= cfg.data[KIND_W-1:0];
        REG_KEYGUARD_ALLOWED: keyguard_allowed <= cfg.data[0];
        REG_TIMEOUT_TICKS:    timeout_ticks    <= cfg.data[TIMER_W-1:0];
        REG_PAIR_COUNT:       pair_count       <= cfg.data[COUNT_W-1:0];
        REG_PAIR_TABLE:       pair_table       <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance    = !res_valid || result.ready;
  assign item.ready = !s1_valid || advance;
  assign process    = s1_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_action <= item.action;
      s1_code   <= item.scan_code;
    end
  end

  // pair fields; pairs past the table end read as zero
  assign pair_table_ext = {{(EXT_W - TABLE_W){1'b0}}, pair_table};

  for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_pair
    assign pair_word[g] = pair_table_ext[g*PAIR_W +: PAIR_W];
    assign prim[g]      = pair_word[g][PAIR_W-1:CODE_BITS];
    assign sec[g]       = pair_word[g][CODE_BITS-1:0];
  end

  // effective pair count, clamped to the table size
  assign eff_count = (pair_count > COUNT_W'(NUM_PAIRS)) ? COUNT_W'(NUM_PAIRS) : pair_count;
  assign code_ext  = CODE_BITS'(s1_code);

  // parallel compare against every pair
  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      prim_hit[i] = (COUNT_W'(i) < eff_count) && (prim[i] == code_ext);
      sec_hit[i]  = (COUNT_W'(i) < eff_count) && candidate_mask[i] && (sec[i] == code_ext);
    end
  end

  // lowest matching primary index
  always_comb begin
    first_idx = '0;
    for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
      if (prim_hit[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign enabled   = (eff_count != '0) &&
                     (keyguard_allowed || (policy_kind != KIND_ACTIVATE_KEYGUARD));
  assign timer_inc = (timer_count != TIMER_MAX) ? timer_count + 16'd1 : timer_count;

  // next state for one item
  always_comb begin
    pending_next        = pending;
    last_valid_next     = last_valid;
    last_index_next     = last_index;
    candidate_mask_next = candidate_mask;
    timer_armed_next    = timer_armed;
    timer_count_next    = timer_count;
    match_next          = 1'b0;
    if (s1_action == ACTION_KEY_DOWN) begin
      if (enabled) begin
        // secondary check closes any open window
        if (pending) begin
          timer_armed_next    = 1'b0;
          candidate_mask_next = '0;
        end
        if (pending && (sec_hit != '0)) begin
          match_next = 1'b1;
        end else if (prim_hit != '0) begin
          last_index_next = first_idx;
          last_valid_next = 1'b1;
          if (policy_kind == KIND_DEVICELOCK_QUERY) begin
            match_next = 1'b1;
          end else begin
            candidate_mask_next = prim_hit;
            timer_armed_next    = 1'b1;
            timer_count_next    = '0;
            pending_next        = 1'b1;
          end
        end else begin
          // unknown key
          pending_next        = 1'b0;
          timer_armed_next    = 1'b0;
          last_valid_next     = 1'b0;
          candidate_mask_next = '0;
        end
      end
    end else if (timer_armed) begin
      timer_count_next = timer_inc;
      if (timer_inc >= timeout_ticks) begin
        pending_next     = 1'b0;
        last_valid_next  = 1'b0;
        timer_armed_next = 1'b0;
      end
    end
  end

  // primary code shown in the result
  always_comb begin
    sel_code = '0;
    for (int i = 0; i < NUM_PAIRS; i++) begin
      if (last_index_next == IDX_W'(i)) begin
        sel_code = prim[i][SCAN_W-1:0];
      end
    end
  end

  assign shown_next = (last_valid_next && ({1'b0, last_index_next} < eff_count)) ?
                      sel_code : '0;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= 1'b0;
      last_valid     <= 1'b0;
      last_index     <= '0;
      candidate_mask <= '0;
      timer_armed    <= 1'b0;
      timer_count    <= '0;
    end else if (process) begin
      pending        <= pending_next;
      last_valid     <= last_valid_next;
      last_index     <= last_index_next;
      candidate_mask <= candidate_mask_next;
      timer_armed    <= timer_armed_next;
      timer_count    <= timer_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_match   <= match_next;
      res_pending <= pending_next;
      res_code    <= shown_next;
    end
  end

  assign result.valid             = res_valid;
  assign result.match             = res_match;
  assign result.primary_pending   = res_pending;
  assign result.last_primary_code = res_code;

  // an armed window always belongs to a pending primary
  assert property (@(posedge clk) disable iff (rst) timer_armed |-> pending)
    else $error("timer armed without pending primary");

  // an armed window always has candidates
  assert property (@(posedge clk) disable iff (rst) timer_armed |-> (candidate_mask != '0))
    else $error("timer armed with empty candidate mask");

  // a tick never reports a match
  assert property (@(posedge clk) disable iff (rst)
    (process && (s1_action == ACTION_TICK)) |=> !res_match)
    else $error("match reported on a timer tick");

  // with the result stage free the block takes input
  assert property (@(posedge clk) disable iff (rst) !res_valid |-> item.ready)
    else $error("input stalled while result stage is empty");

endmodule
